// ===== rtl/core/array_tree_table_with_traversals_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array tree table
// Shared shorthands for the concurrent checks in the RTL. They expect a
// clock named clk and an active-high reset named rst in the using module.
// ----------------------------------------------------------------------------
`ifndef ARRAY_TREE_TABLE_WITH_TRAVERSALS_DEFINES_SVH
`define ARRAY_TREE_TABLE_WITH_TRAVERSALS_DEFINES_SVH

// Same-cycle implication
`define ATT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// Types and codes shared by the array tree table controller and datapath.
// ----------------------------------------------------------------------------
package att_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_LEVEL  = 3'd4,
    CMD_PRE    = 3'd5,
    CMD_IN     = 3'd6,
    CMD_POST   = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Direction of arrival at a tree node during a walk
  typedef enum logic [1:0] {
    DIR_DOWN   = 2'd0,
    DIR_FROM_L = 2'd1,
    DIR_FROM_R = 2'd2
  } dir_t;

  // Read address source
  typedef enum logic {
    RD_POS  = 1'b0,
    RD_LAST = 1'b1
  } rd_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INSERT,
    S_CLEAR,
    S_EMPTY,
    S_SCAN,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_HIT,
    S_MISS,
    S_LVL,
    S_LVL_EMIT,
    S_WALK,
    S_WALK_EMIT,
    S_FLUSH
  } state_t;

  // Input item
  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
  } item_t;

  // Result item
  typedef struct packed {
    status_t            status;
    logic signed [31:0] value_out;
    logic               last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    pos_init;
    logic    pos_inc;
    logic    walk_step;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_ins;
    logic    wr_del;
    logic    cnt_clear;
    logic    push;
    status_t push_status;
    logic    push_last;
    logic    push_pend;
    logic    pend_load;
    logic    pend_clear;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic count_zero;
    logic full;
    logic pos_zero;
    logic beyond;
    logic hit;
    logic walk_emit;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

// ===== rtl/core/att_ctrl.sv =====
// ----------------------------------------------------------------------------
// att_ctrl
// Command sequencer: dispatches each command and steps the datapath through
// scans, deletes and tree walks one action per cycle, holding while the output is busy.
// ----------------------------------------------------------------------------
module att_ctrl
  import att_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  // a buffered value can move on when nothing is held or the output is free
  logic emit_ok;
  assign emit_ok = !sts.pend_valid || sts.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.cmd)
          CMD_INSERT: state_next = S_INSERT;
          CMD_SEARCH,
          CMD_DELETE: state_next = S_SCAN;
          CMD_CLEAR:  state_next = S_CLEAR;
          CMD_LEVEL:  state_next = sts.count_zero ? S_EMPTY : S_LVL;
          default:    state_next = sts.count_zero ? S_EMPTY : S_WALK;
        endcase
      end
      S_INSERT, S_CLEAR, S_EMPTY, S_HIT, S_MISS, S_FLUSH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        state_next = sts.beyond ? S_MISS : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.hit) begin
          state_next = (sts.cmd == CMD_DELETE) ? S_DEL_RD : S_HIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_DEL_RD: state_next = S_DEL_WR;
      S_DEL_WR: state_next = S_HIT;
      S_LVL: begin
        state_next = sts.beyond ? S_FLUSH : S_LVL_EMIT;
      end
      S_LVL_EMIT: begin
        if (emit_ok) state_next = S_LVL;
      end
      S_WALK: begin
        if (sts.pos_zero) begin
          state_next = S_FLUSH;
        end else if (sts.walk_emit) begin
          state_next = S_WALK_EMIT;
        end
      end
      S_WALK_EMIT: begin
        if (emit_ok) state_next = S_WALK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    ctl.rd_sel = RD_POS;
    ctl.push_status = ST_OK;
    cmd_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // no transfer while reset is held
        cmd_ready = !rst;
        ctl.load_item = cmd_valid && !rst;
      end
      S_DISPATCH: begin
        ctl.pos_init = 1'b1;
      end
      S_INSERT: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
          ctl.push_status = sts.full ? ST_FULL : ST_OK;
          ctl.wr_ins = !sts.full;
        end
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
          ctl.cnt_clear = 1'b1;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
          ctl.push_status = ST_EMPTY;
        end
      end
      S_HIT: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
          ctl.push_status = ST_NOT_FOUND;
        end
      end
      S_SCAN: begin
        ctl.rd_en = !sts.beyond;
      end
      S_SCAN_CMP: begin
        ctl.pos_inc = !sts.hit;
      end
      S_DEL_RD: begin
        ctl.rd_en = 1'b1;
        ctl.rd_sel = RD_LAST;
      end
      S_DEL_WR: begin
        ctl.wr_del = 1'b1;
      end
      S_LVL: begin
        ctl.rd_en = !sts.beyond;
      end
      S_LVL_EMIT, S_WALK_EMIT: begin
        ctl.push = sts.pend_valid && sts.out_free;
        ctl.push_pend = 1'b1;
        ctl.pend_load = emit_ok;
        ctl.pos_inc = emit_ok && (state == S_LVL_EMIT);
      end
      S_WALK: begin
        if (!sts.pos_zero) begin
          ctl.walk_step = 1'b1;
          ctl.rd_en = sts.walk_emit;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          ctl.push = 1'b1;
          ctl.push_last = 1'b1;
          ctl.push_pend = 1'b1;
          ctl.pend_clear = 1'b1;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/att_dpath.sv =====
// ----------------------------------------------------------------------------
// att_dpath
// Entry memory, count, walk position, one-deep lookahead buffer for the
// last-flag, and the result register.
// ----------------------------------------------------------------------------
`include "array_tree_table_with_traversals_defines.svh"

module att_dpath
  import att_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   cmd,
  input  ctl_t    ctl,
  output sts_t    sts,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output result_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 1;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [31:0] mem [CAPACITY];

  cmd_t               cur_cmd;
  logic signed [31:0] cur_value;
  logic [CW-1:0]      count;
  logic [PW-1:0]      pos;
  dir_t               dir;
  logic signed [31:0] rdata;
  logic               pend_valid;
  logic signed [31:0] pend_value;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               beyond;
  logic               emit;

  // command latch
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cur_cmd   <= cmd.command;
      cur_value <= cmd.value;
    end
  end

  // position of a node past the stored count is an empty child
  assign beyond = pos > PW'(count);

  // a node is emitted on the arrival that matches the traversal order
  always_comb begin
    case (dir)
      DIR_DOWN:   emit = !beyond && (cur_cmd == CMD_PRE);
      DIR_FROM_L: emit = (cur_cmd == CMD_IN);
      DIR_FROM_R: emit = (cur_cmd == CMD_POST);
      default:    emit = 1'b0;
    endcase
  end

  // walk position: down to left child, over to right child, or up to parent
  always_ff @(posedge clk) begin
    if (ctl.pos_init) begin
      pos <= PW'(1);
      dir <= DIR_DOWN;
    end else if (ctl.pos_inc) begin
      pos <= pos + PW'(1);
    end else if (ctl.walk_step) begin
      case (dir)
        DIR_DOWN: begin
          if (beyond) begin
            pos <= pos >> 1;
            dir <= pos[0] ? DIR_FROM_R : DIR_FROM_L;
          end else begin
            pos <= pos << 1;
          end
        end
        DIR_FROM_L: begin
          pos <= {pos[PW-2:0], 1'b1};
          dir <= DIR_DOWN;
        end
        default: begin
          pos <= pos >> 1;
          dir <= pos[0] ? DIR_FROM_R : DIR_FROM_L;
        end
      endcase
    end
  end

  // stored entry count
  always_ff @(posedge clk) begin
    if (rst || ctl.cnt_clear) begin
      count <= '0;
    end else if (ctl.wr_ins) begin
      count <= count + CW'(1);
    end else if (ctl.wr_del) begin
      count <= count - CW'(1);
    end
  end

  // memory addressing: tree position p lives at entry p-1
  assign raddr = (ctl.rd_sel == RD_LAST) ? AW'(count - CW'(1)) : AW'(pos - PW'(1));
  assign waddr = ctl.wr_ins ? AW'(count) : AW'(pos - PW'(1));
  assign wdata = ctl.wr_ins ? cur_value : rdata;

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_ins || ctl.wr_del) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // lookahead buffer: a value is sent only once the next one, or the end,
  // is known, so the final one can carry the last flag
  always_ff @(posedge clk) begin
    if (rst || ctl.pend_clear) begin
      pend_valid <= 1'b0;
    end else if (ctl.pend_load) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pend_load) begin
      pend_value <= rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      rsp.status    <= ctl.push_status;
      rsp.value_out <= ctl.push_pend ? pend_value : 32'sd0;
      rsp.last      <= ctl.push_last;
    end
  end

  // status to the controller
  always_comb begin
    sts.cmd        = cur_cmd;
    sts.count_zero = (count == '0);
    sts.full       = (count >= CW'(CAPACITY));
    sts.pos_zero   = (pos == '0);
    sts.beyond     = beyond;
    sts.hit        = (rdata == cur_value);
    sts.walk_emit  = emit;
    sts.out_free   = !rsp_valid || rsp_ready;
    sts.pend_valid = pend_valid;
  end

  // checks
  `ATT_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(CAPACITY), "count exceeds capacity")
  `ATT_ASSERT_IMP(a_push_free, ctl.push, !rsp_valid || rsp_ready, "result overwritten")
  `ATT_ASSERT_IMP(a_read_pos, ctl.rd_en && (ctl.rd_sel == RD_POS), (pos != '0) && !beyond, "read outside stored range")
  `ATT_ASSERT_IMP(a_flush_pend, ctl.pend_clear, pend_valid, "flush with empty buffer")
  `ATT_ASSERT_NXT(a_insert_cnt, ctl.wr_ins, count == $past(count) + CW'(1), "insert count step")

endmodule

// ===== rtl/core/array_tree_table_with_traversals.sv =====
// ----------------------------------------------------------------------------
// array_tree_table_with_traversals
// Table of signed 32-bit values kept as an implicit complete binary tree,
// with insert, search, delete, clear and four traversals.
// ----------------------------------------------------------------------------
// One command is taken at a time; a new one is accepted as soon as the
// previous command's last result has been loaded into the output register,
// even if that result is still waiting to be taken. The entry memory has a
// registered read, and a walk makes one tree move per cycle, pausing
// whenever a value is emitted. Search and delete scan the entries in order,
// reading and comparing each; a delete then moves the last entry into the
// freed place. Level order reads the entries in order. Pre, in and post
// order walk the tree: three arrivals per stored node and one per empty
// child, and a value is emitted on the arrival that matches the order.
// The entry store is not cleared at reset; only entries below the count
// are ever read. Results are held while the consumer stalls.
// ----------------------------------------------------------------------------
module array_tree_table_with_traversals
  import att_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  item_t   cmd,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output result_t rsp
);

  ctl_t ctl;
  sts_t sts;

  // sequencer
  att_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage and result path
  att_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
